>>> rtl/fsgb_pkg.sv
// Font sheet glyph blitter: shared constants, word types and the
// controller/datapath command and status structs.
// No dependencies; every other file uses this package.
`default_nettype none

package fsgb_pkg;

  // Sheet store geometry (depth is a power of two, addresses wrap)
  localparam int SHEET_DEPTH    = 16384;
  localparam int SHEET_AW       = $clog2(SHEET_DEPTH);
  localparam int MAX_GLYPH_SIDE = 8;
  localparam int SCREEN_X_MAX   = 799;

  // Field widths
  localparam int SIDE_W    = 4;
  localparam int CPR_W     = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int ADDR_IN_W = 14;
  localparam int CODE_W    = 8;
  localparam int POS_W     = 7;
  localparam int XY_W      = 10;
  localparam int COLOR_W   = 32;

  // Internal widths
  localparam int CNT_W     = (MAX_GLYPH_SIDE > 1) ? $clog2(MAX_GLYPH_SIDE) : 1;
  localparam int CELL_W    = 7;
  localparam int DIV_STEPS = CELL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int MUL_W     = CPR_W + SIDE_W;
  localparam int ROWP_W    = 2 * MUL_W;
  localparam int BX_W      = 12;

  // Printable range
  localparam logic [CODE_W-1:0] FIRST_CODE = 8'd32;
  localparam logic [CODE_W-1:0] LAST_CODE  = 8'd126;

  // Item kinds
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_ROW = 2'd2;

  // Reset values of the registers
  localparam logic [SIDE_W-1:0] GLYPH_WIDTH_RST  = 4'd8;
  localparam logic [SIDE_W-1:0] GLYPH_HEIGHT_RST = 4'd8;
  localparam logic [CPR_W-1:0]  CELLS_PER_ROW_RST = 7'd16;

  typedef struct packed {
    logic                 func;
    logic [ADDR_IN_W-1:0] sheet_address;
    logic                 sheet_black;
    logic [CODE_W-1:0]    char_code;
    logic [POS_W-1:0]     char_position;
    logic [XY_W-1:0]      origin_x;
    logic [XY_W-1:0]      origin_y;
    logic [COLOR_W-1:0]   pen_color;
  } in_word_t;

  typedef struct packed {
    logic [XY_W-1:0]    pixel_x;
    logic [XY_W-1:0]    pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } out_word_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;   // input word taken this cycle
    logic div_step; // one quotient bit
    logic setup;    // cell origin, sheet width, screen base
    logic rowbase;  // first row address, clear scan counters
    logic scan;     // issue one sheet read
    logic flush;    // send the held pixel as the last one
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic draw_req;   // input word is a printable draw
    logic div_last;   // final quotient bit this cycle
    logic scan_last;  // read of the final glyph pixel pending
    logic stall;      // check stage blocked by the output
    logic chk_valid;  // check stage holds a read
    logic pend_valid; // a pixel waits for its successor
    logic out_free;   // output register can load this cycle
  } sts_t;

  // Zero counts as one, oversize as the maximum side
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] res;
    if (v == '0) begin
      res = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_GLYPH_SIDE)) begin
      res = SIDE_W'(MAX_GLYPH_SIDE);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fsgb_if.sv
// Valid/ready channels of the glyph blitter: input words and pixel words.
// No dependencies beyond the package widths.
`default_nettype none

interface fsgb_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [fsgb_pkg::ADDR_IN_W-1:0] sheet_address;
  logic                           sheet_black;
  logic [fsgb_pkg::CODE_W-1:0]    char_code;
  logic [fsgb_pkg::POS_W-1:0]     char_position;
  logic [fsgb_pkg::XY_W-1:0]      origin_x;
  logic [fsgb_pkg::XY_W-1:0]      origin_y;
  logic [fsgb_pkg::COLOR_W-1:0]   pen_color;

  modport source (output valid, func, sheet_address, sheet_black, char_code,
                  char_position, origin_x, origin_y, pen_color, input ready);
  modport sink   (input valid, func, sheet_address, sheet_black, char_code,
                  char_position, origin_x, origin_y, pen_color, output ready);
endinterface

interface fsgb_out_if;
  logic                         valid;
  logic                         ready;
  logic [fsgb_pkg::XY_W-1:0]    pixel_x;
  logic [fsgb_pkg::XY_W-1:0]    pixel_y;
  logic [fsgb_pkg::COLOR_W-1:0] pixel_color;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/fsgb_ctrl.sv
// Glyph blitter controller: sequences accept, cell divide, setup,
// sheet scan, drain and final flush. Depends on fsgb_pkg.
`default_nettype none

module fsgb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire fsgb_pkg::sts_t sts,
  output logic               in_ready,
  output fsgb_pkg::cmd_t     cmd
);
  import fsgb_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_ROWB  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_FLUSH = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.draw_req) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_ROWB;
      end
      ST_ROWB: begin
        cmd.rowbase = 1'b1;
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last && !sts.stall) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.chk_valid) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (!sts.pend_valid || sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fsgb_dp.sv
// Glyph blitter datapath: registers, sheet mask memory, serial cell
// divider, scan counters, check stage, held pixel and output register.
// Depends on fsgb_pkg.
`default_nettype none

module fsgb_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [fsgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsgb_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire fsgb_pkg::in_word_t          in_word,
  input  wire fsgb_pkg::cmd_t              cmd,
  input  wire logic                        out_ready,
  output fsgb_pkg::sts_t                   sts,
  output logic                             out_valid,
  output fsgb_pkg::out_word_t              out_word
);
  import fsgb_pkg::*;

  // Configuration registers
  logic [SIDE_W-1:0] gw_cfg_r, gh_cfg_r;
  logic [CPR_W-1:0]  cpr_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_cfg_r  <= GLYPH_WIDTH_RST;
      gh_cfg_r  <= GLYPH_HEIGHT_RST;
      cpr_cfg_r <= CELLS_PER_ROW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GLYPH_WIDTH:   gw_cfg_r  <= cfg_wdata[SIDE_W-1:0];
        CFG_GLYPH_HEIGHT:  gh_cfg_r  <= cfg_wdata[SIDE_W-1:0];
        CFG_CELLS_PER_ROW: cpr_cfg_r <= cfg_wdata[CPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [SIDE_W-1:0] gw_eff, gh_eff;
  logic [CPR_W-1:0]  cpr_eff;
  logic [CNT_W-1:0]  gw_m1, gh_m1;

  assign gw_eff  = clamp_side(gw_cfg_r);
  assign gh_eff  = clamp_side(gh_cfg_r);
  assign cpr_eff = (cpr_cfg_r == '0) ? CPR_W'(1) : cpr_cfg_r;
  assign gw_m1   = CNT_W'(gw_eff - SIDE_W'(1));
  assign gh_m1   = CNT_W'(gh_eff - SIDE_W'(1));

  // Input decode
  logic printable;
  assign printable    = (in_word.char_code >= FIRST_CODE) &&
                        (in_word.char_code <= LAST_CODE);
  assign sts.draw_req = (in_word.func == FUNC_DRAW) && printable;

  // Draw item latch
  logic [XY_W-1:0]    ox_r, oy_r;
  logic [POS_W-1:0]   pos_r;
  logic [COLOR_W-1:0] color_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ox_r    <= in_word.origin_x;
      oy_r    <= in_word.origin_y;
      pos_r   <= in_word.char_position;
      color_r <= in_word.pen_color;
    end
  end

  // Restoring divider: cell index by cells per row, one bit a cycle
  logic [CELL_W-1:0]    quo_r, rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CELL_W:0]      trial;
  logic                 trial_ge;

  assign trial        = {rem_r, quo_r[CELL_W-1]};
  assign trial_ge     = trial >= (CELL_W+1)'(cpr_eff);
  assign sts.div_last = div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      quo_r     <= CELL_W'(in_word.char_code - FIRST_CODE);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= trial_ge ? CELL_W'(trial - (CELL_W+1)'(cpr_eff)) : trial[CELL_W-1:0];
      quo_r     <= {quo_r[CELL_W-2:0], trial_ge};
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // Cell origin, sheet width and screen base
  logic [MUL_W-1:0]    x0_r, y0_r, sw_r;
  logic [BX_W-1:0]     bx_r;
  logic [ROWP_W-1:0]   row_prod;
  logic [SHEET_AW-1:0] row_addr_r;
  logic [CNT_W-1:0]    col_r, row_r;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      x0_r <= MUL_W'(rem_r) * MUL_W'(gw_eff);
      y0_r <= MUL_W'(quo_r) * MUL_W'(gh_eff);
      sw_r <= MUL_W'(cpr_eff) * MUL_W'(gw_eff);
      bx_r <= BX_W'(ox_r) + BX_W'(pos_r) * BX_W'(gw_eff);
    end
  end

  assign row_prod = ROWP_W'(y0_r) * ROWP_W'(sw_r) + ROWP_W'(x0_r);

  // Scan counters, row-major over the glyph
  logic                rd_en;
  logic [SHEET_AW-1:0] rd_addr;

  assign rd_en         = cmd.scan && !sts.stall;
  assign rd_addr       = row_addr_r + SHEET_AW'(col_r);
  assign sts.scan_last = (col_r == gw_m1) && (row_r == gh_m1);

  always_ff @(posedge clk) begin
    if (cmd.rowbase) begin
      row_addr_r <= row_prod[SHEET_AW-1:0];
      col_r      <= '0;
      row_r      <= '0;
    end else if (rd_en) begin
      if (col_r == gw_m1) begin
        col_r      <= '0;
        row_r      <= row_r + CNT_W'(1);
        row_addr_r <= row_addr_r + SHEET_AW'(sw_r);
      end else begin
        col_r <= col_r + CNT_W'(1);
      end
    end
  end

  // Sheet mask memory: one write port, one registered read port
  logic mask_mem [SHEET_DEPTH];
  logic rd_q_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_word.func == FUNC_LOAD)) begin
      mask_mem[SHEET_AW'(in_word.sheet_address)] <= in_word.sheet_black;
    end
    if (rd_en) begin
      rd_q_r <= mask_mem[rd_addr];
    end
  end

  // Check stage: coordinates of the read in flight
  logic             chk_valid_r;
  logic [CNT_W-1:0] chk_col_r, chk_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_valid_r <= 1'b0;
    end else if (!sts.stall) begin
      chk_valid_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (!sts.stall) begin
      chk_col_r <= col_r;
      chk_row_r <= row_r;
    end
  end

  // Screen position of the checked pixel
  logic [BX_W-1:0] px_sum, px;
  logic [XY_W-1:0] py;

  assign px_sum = bx_r + BX_W'(chk_col_r);
  assign px     = (px_sum > BX_W'(SCREEN_X_MAX)) ? BX_W'(SCREEN_X_MAX) : px_sum;
  assign py     = oy_r + XY_W'(chk_row_r);

  // Held pixel: sent once the next black pixel or the end is known
  logic            pend_valid_r;
  logic [XY_W-1:0] pend_x_r, pend_y_r;
  logic            out_valid_r;
  logic            hit, push_mid, push_last;

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.stall      = chk_valid_r && rd_q_r && pend_valid_r && !sts.out_free;
  assign sts.chk_valid  = chk_valid_r;
  assign sts.pend_valid = pend_valid_r;

  assign hit       = chk_valid_r && rd_q_r && !sts.stall;
  assign push_mid  = hit && pend_valid_r;
  assign push_last = cmd.flush && pend_valid_r && sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (hit) begin
      pend_valid_r <= 1'b1;
    end else if (push_last) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      pend_x_r <= px[XY_W-1:0];
      pend_y_r <= py;
    end
  end

  // Output register
  out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_mid || push_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_last) begin
      out_word_r.pixel_x     <= pend_x_r;
      out_word_r.pixel_y     <= pend_y_r;
      out_word_r.pixel_color <= color_r;
      out_word_r.last_pixel  <= push_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

>>> rtl/font_sheet_glyph_blitter_top.sv
// Font sheet glyph blitter, top level: controller plus datapath.
// Depends on fsgb_pkg, fsgb_if, fsgb_ctrl and fsgb_dp.
//
// Usage:
//   in_if carries one word per item. func 0 stores sheet_black at
//   sheet_address of the font sheet mask; func 1 draws char_code.
//   out_if carries one pixel write per black glyph pixel, row-major,
//   with last_pixel set on the final write of the character.
//   cfg_we/cfg_index/cfg_wdata write glyph_width (0), glyph_height (1)
//   and cells_per_row (2); write only while the block is idle.
// Sequence:
//   A load or an unprintable code goes straight back to idle. A draw
//   runs a serial cell divide, setup, then one sheet mask read per
//   glyph pixel through the single read port, then drain and flush.
//   in_if.ready is high only between items.
// Reset: controller idle, registers at 8/8/16, output empty. The sheet
//   mask is not cleared and must be loaded before use.
// Backpressure: the output register holds its word while out_if.ready
//   is low; the scan pauses only when a second black pixel is found.
`default_nettype none

module font_sheet_glyph_blitter_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  fsgb_in_if.sink                             in_if,
  fsgb_out_if.source                          out_if,
  input  wire logic                           cfg_we,
  input  wire logic [fsgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsgb_pkg::CFG_W-1:0]     cfg_wdata
);
  import fsgb_pkg::*;

  in_word_t  in_word;
  out_word_t out_word;
  cmd_t      cmd;
  sts_t      sts;
  logic      in_ready;
  logic      out_valid;

  // Pack the input word
  assign in_word.func          = in_if.func;
  assign in_word.sheet_address = in_if.sheet_address;
  assign in_word.sheet_black   = in_if.sheet_black;
  assign in_word.char_code     = in_if.char_code;
  assign in_word.char_position = in_if.char_position;
  assign in_word.origin_x      = in_if.origin_x;
  assign in_word.origin_y      = in_if.origin_y;
  assign in_word.pen_color     = in_if.pen_color;

  fsgb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  fsgb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .out_ready (out_if.ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // Channel outputs
  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid;
  assign out_if.pixel_x     = out_word.pixel_x;
  assign out_if.pixel_y     = out_word.pixel_y;
  assign out_if.pixel_color = out_word.pixel_color;
  assign out_if.last_pixel  = out_word.last_pixel;

`ifndef SYNTHESIS
  // Between items the check stage and the held pixel are empty
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (!sts.pend_valid && !sts.chk_valid))
    else $error("item accepted with pixel work still pending");

  // A stall needs both a checked read and a held pixel
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    sts.stall |-> (sts.pend_valid && sts.chk_valid))
    else $error("scan stalled without a held pixel");

  // The final flush empties the held pixel
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.flush && sts.pend_valid && sts.out_free) |=> !sts.pend_valid)
    else $error("held pixel survived the final flush");

  // A fresh draw never starts scanning with a held pixel
  a_rowbase_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rowbase |-> !sts.pend_valid)
    else $error("held pixel present at start of scan");
`endif

endmodule

`default_nettype wire

>>> sim/fsgb_pixel_checker.sv
// Pixel checker for the font sheet glyph blitter: watches the word channels
// and the register port, predicts every pixel write and compares them in order.
// Depends on fsgb_pkg and fsgb_if.
`timescale 1ns / 100ps

module fsgb_pixel_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  fsgb_in_if                                  in_if,
  fsgb_out_if                                 out_if,
  input  wire logic                           cfg_we,
  input  wire logic [fsgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsgb_pkg::CFG_W-1:0]     cfg_wdata,
  output int                                  errors,
  output int                                  outstanding
);

  import fsgb_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Shadow registers and sheet mask
  logic [SIDE_W-1:0] width_reg;
  logic [SIDE_W-1:0] height_reg;
  logic [CPR_W-1:0]  cpr_reg;
  bit                sheet_bits [0:SHEET_DEPTH-1];

  out_word_t pixels_due [$];
  int        err_cnt = 0;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  // Zero side counts as one, oversize as the largest glyph side
  function automatic int side_used(input logic [SIDE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_GLYPH_SIDE) return MAX_GLYPH_SIDE;
    return int'(v);
  endfunction

  // Walk the glyph cell row-major, one pixel write per black sheet pixel
  task automatic predict_glyph(input in_word_t w);
    int        gw, gh, cpr, cell_idx, x0, y0, sheet_w, base_x, px, py, addr;
    out_word_t pix, held;
    bit        have_held;
    have_held = 1'b0;
    held      = '0;
    if (w.char_code < FIRST_CODE || w.char_code > LAST_CODE) return;
    gw       = side_used(width_reg);
    gh       = side_used(height_reg);
    cpr      = (cpr_reg == 0) ? 1 : cpr_reg;
    cell_idx = w.char_code - FIRST_CODE;
    x0       = (cell_idx % cpr) * gw;
    y0       = (cell_idx / cpr) * gh;
    sheet_w  = gw * cpr;
    base_x   = w.origin_x + w.char_position * gw;
    for (int r = 0; r < gh; r++) begin
      for (int c = 0; c < gw; c++) begin
        addr = ((x0 + c) + (y0 + r) * sheet_w) % SHEET_DEPTH;
        if (sheet_bits[addr]) begin
          px = base_x + c;
          if (px > SCREEN_X_MAX) px = SCREEN_X_MAX;
          py = w.origin_y + r;
          pix.pixel_x     = px[XY_W-1:0];
          pix.pixel_y     = py[XY_W-1:0];
          pix.pixel_color = w.pen_color;
          pix.last_pixel  = 1'b0;
          // hold one back so the final one can be marked
          if (have_held) pixels_due.push_back(held);
          held      = pix;
          have_held = 1'b1;
        end
      end
    end
    if (have_held) begin
      held.last_pixel = 1'b1;
      pixels_due.push_back(held);
    end
  endtask

  always @(posedge clk) begin : watch
    in_word_t  word;
    out_word_t got, want;
    if (!rst_n) begin
      width_reg  <= GLYPH_WIDTH_RST;
      height_reg <= GLYPH_HEIGHT_RST;
      cpr_reg    <= CELLS_PER_ROW_RST;
      pixels_due.delete();
    end else begin
      // register writes (never in the same cycle as an input word)
      if (cfg_we) begin
        case (cfg_index)
          CFG_GLYPH_WIDTH:   width_reg  <= cfg_wdata[SIDE_W-1:0];
          CFG_GLYPH_HEIGHT:  height_reg <= cfg_wdata[SIDE_W-1:0];
          CFG_CELLS_PER_ROW: cpr_reg    <= cfg_wdata[CPR_W-1:0];
          default: ;
        endcase
      end

      // pixel word out: compare with the oldest prediction
      if (out_if.valid && out_if.ready) begin
        got.pixel_x     = out_if.pixel_x;
        got.pixel_y     = out_if.pixel_y;
        got.pixel_color = out_if.pixel_color;
        got.last_pixel  = out_if.last_pixel;
        if (pixels_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_LIMIT)
            $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $realtime,
                     got.pixel_x, got.pixel_y, got.pixel_color, got.last_pixel);
        end else begin
          want = pixels_due.pop_front();
          if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
              got.pixel_color !== want.pixel_color ||
              got.last_pixel !== want.last_pixel) begin
            err_cnt++;
            if (err_cnt <= REPORT_LIMIT)
              $display({"%0t: pixel mismatch exp x=%0d y=%0d color=%h last=%b,",
                        " got x=%0d y=%0d color=%h last=%b"},
                       $realtime, want.pixel_x, want.pixel_y, want.pixel_color,
                       want.last_pixel, got.pixel_x, got.pixel_y, got.pixel_color,
                       got.last_pixel);
          end
        end
      end

      // input word in: store a mask bit or predict a glyph
      if (in_if.valid && in_if.ready) begin
        word.func          = in_if.func;
        word.sheet_address = in_if.sheet_address;
        word.sheet_black   = in_if.sheet_black;
        word.char_code     = in_if.char_code;
        word.char_position = in_if.char_position;
        word.origin_x      = in_if.origin_x;
        word.origin_y      = in_if.origin_y;
        word.pen_color     = in_if.pen_color;
        if (word.func == FUNC_LOAD)
          sheet_bits[word.sheet_address % SHEET_DEPTH] = word.sheet_black;
        else
          predict_glyph(word);
      end
    end
    errors      <= err_cnt;
    outstanding <= pixels_due.size();
  end

endmodule

>>> sim/font_sheet_glyph_blitter_top_tb.sv
// Testbench top for the font sheet glyph blitter: clock, reset, register
// settings and input words with random gaps; verdict from fsgb_pixel_checker.
// Depends on fsgb_pkg, fsgb_if, the blitter RTL and sim/fsgb_pixel_checker.sv.
`timescale 1ns / 100ps

module font_sheet_glyph_blitter_top_tb;

  import fsgb_pkg::*;

  localparam int HALF_PERIOD       = 4;
  localparam int RESET_CYCLES      = 9;
  localparam int SETTLE_CYCLES     = 100;
  localparam int LONG_HOLD         = 400;
  localparam int N_SETTINGS        = 8;
  localparam int ITEMS_PER_SETTING = 20;
  localparam int POOL_SIZE         = 4;
  localparam int SCREEN_Y_MAX      = 599;
  localparam int LIMIT_NS          = 40_000_000;

  // index 3 names no register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum {FILL_MISSING, FILL_RANDOM, FILL_BLANK, FILL_SOLID} fill_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   errors;
  int                   outstanding;

  fsgb_in_if  in_ch ();
  fsgb_out_if out_ch ();

  font_sheet_glyph_blitter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fsgb_pixel_checker pixel_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Glyph geometry as currently programmed, and which mask bits were loaded
  int eff_w   = 8;
  int eff_h   = 8;
  int eff_cpr = 16;
  bit loaded [0:SHEET_DEPTH-1];

  int calm_words = 0;
  int hold_req   = 0;
  int items_sent = 0;

  // Printable codes drawn under the current geometry
  logic [CODE_W-1:0] code_pool [0:POOL_SIZE-1];

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Run limit
  initial begin : watchdog
    #(LIMIT_NS);
    $display("font_sheet_glyph_blitter_top_tb NOT OK");
    $finish;
  end

  // Output ready: short and long stalls, calm stretches, one long hold on request
  initial begin : out_ready_gen
    int stall_left, calm_left, holds_done, pick;
    stall_left   = 0;
    calm_left    = 0;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != holds_done) begin
        holds_done = holds_done + 1;
        stall_left = LONG_HOLD;
        calm_left  = 0;
      end
      if (stall_left == 0 && calm_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)       stall_left = $urandom_range(8, 30);
        else if (pick < 28) stall_left = $urandom_range(1, 3);
        else if (pick < 32) calm_left  = $urandom_range(30, 150);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (calm_left > 0) calm_left--;
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic int side_used(input logic [SIDE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_GLYPH_SIDE) return MAX_GLYPH_SIDE;
    return int'(v);
  endfunction

  // Sheet index of pixel (r, c) of a glyph under the current geometry
  function automatic int glyph_addr(input logic [CODE_W-1:0] code, input int r, input int c);
    int cell_idx;
    cell_idx = code - FIRST_CODE;
    return ((cell_idx % eff_cpr) * eff_w + c +
            ((cell_idx / eff_cpr) * eff_h + r) * eff_w * eff_cpr) % SHEET_DEPTH;
  endfunction

  // Random contents for the fields the item kind does not use
  function automatic in_word_t scrambled_word();
    in_word_t w;
    w.func          = FUNC_LOAD;
    w.sheet_address = $urandom_range(0, SHEET_DEPTH - 1);
    w.sheet_black   = $urandom_range(0, 1);
    w.char_code     = $urandom_range(0, 255);
    w.char_position = $urandom_range(0, 127);
    w.origin_x      = $urandom_range(0, SCREEN_X_MAX);
    w.origin_y      = $urandom_range(0, SCREEN_Y_MAX);
    w.pen_color     = $urandom();
    return w;
  endfunction

  function automatic int pick_pos();
    if ($urandom_range(0, 99) < 70) return $urandom_range(0, 10);
    return $urandom_range(0, 127);
  endfunction

  // Gap after a word: mostly none or short, a few long, sometimes a calm run
  task automatic idle_gap();
    int n, pick;
    n    = 0;
    pick = $urandom_range(0, 99);
    if (calm_words > 0) calm_words--;
    else if (pick < 5)  calm_words = $urandom_range(10, 40);
    else if (pick < 50) n = 0;
    else if (pick < 85) n = $urandom_range(1, 3);
    else if (pick < 96) n = $urandom_range(4, 8);
    else                n = $urandom_range(12, 40);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one word and hold it until the block takes it
  task automatic push_word(input in_word_t w);
    in_ch.valid         <= 1'b1;
    in_ch.func          <= w.func;
    in_ch.sheet_address <= w.sheet_address;
    in_ch.sheet_black   <= w.sheet_black;
    in_ch.char_code     <= w.char_code;
    in_ch.char_position <= w.char_position;
    in_ch.origin_x      <= w.origin_x;
    in_ch.origin_y      <= w.origin_y;
    in_ch.pen_color     <= w.pen_color;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    idle_gap();
  endtask

  task automatic load_bit(input int addr, input logic black);
    in_word_t w;
    w               = scrambled_word();
    w.func          = FUNC_LOAD;
    w.sheet_address = addr[ADDR_IN_W-1:0];
    w.sheet_black   = black;
    loaded[addr % SHEET_DEPTH] = 1'b1;
    push_word(w);
  endtask

  task automatic draw_char(input logic [CODE_W-1:0] code, input int pos, input int ox,
                           input int oy, input logic [COLOR_W-1:0] color);
    in_word_t w;
    w               = scrambled_word();
    w.func          = FUNC_DRAW;
    w.char_code     = code;
    w.char_position = pos[POS_W-1:0];
    w.origin_x      = ox[XY_W-1:0];
    w.origin_y      = oy[XY_W-1:0];
    w.pen_color     = color;
    push_word(w);
  endtask

  // Load the mask bits of one glyph; FILL_MISSING touches only unloaded bits
  task automatic paint_glyph(input logic [CODE_W-1:0] code, input fill_mode_t mode);
    int   a, density;
    logic b;
    density = $urandom_range(15, 85);
    for (int r = 0; r < eff_h; r++) begin
      for (int c = 0; c < eff_w; c++) begin
        a = glyph_addr(code, r, c);
        if (mode != FILL_MISSING || !loaded[a]) begin
          case (mode)
            FILL_BLANK: b = 1'b0;
            FILL_SOLID: b = 1'b1;
            default:    b = ($urandom_range(0, 99) < density);
          endcase
          load_bit(a, b);
        end
      end
    end
  endtask

  // Stop offering, wait for every predicted pixel, optionally let the block go idle
  task automatic settle(input bit before_cfg);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    if (before_cfg) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program all three registers, spare index optionally poked
  task automatic write_regs(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                            input logic [CPR_W-1:0] cpr, input bit poke_spare);
    logic [CFG_W-1:0] junk;
    junk      = $urandom();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GLYPH_WIDTH;
    cfg_wdata <= {junk[CFG_W-1:SIDE_W], w};
    @(posedge clk);
    junk      = $urandom();
    cfg_index <= CFG_GLYPH_HEIGHT;
    cfg_wdata <= {junk[CFG_W-1:SIDE_W], h};
    @(posedge clk);
    cfg_index <= CFG_CELLS_PER_ROW;
    cfg_wdata <= cpr;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= CFG_SPARE;
      cfg_wdata <= $urandom();
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    eff_w   = side_used(w);
    eff_h   = side_used(h);
    eff_cpr = (cpr == 0) ? 1 : cpr;
  endtask

  // Short directed run at reset geometry
  task automatic directed_part();
    load_bit(0, 1'b1);
    load_bit(SHEET_DEPTH - 1, 1'b0);
    // full glyph: most pixels per character
    paint_glyph(FIRST_CODE, FILL_SOLID);
    draw_char(FIRST_CODE, 0, 0, 0, '0);
    // x clamped at the right edge, bottom of the screen, all-ones color
    draw_char(FIRST_CODE, 127, SCREEN_X_MAX, SCREEN_Y_MAX, '1);
    // codes just outside the printable range and the byte extremes
    draw_char(8'd0, pick_pos(), 5, 5, $urandom());
    draw_char(FIRST_CODE - 8'd1, pick_pos(), 5, 5, $urandom());
    draw_char(LAST_CODE + 8'd1, pick_pos(), 5, 5, $urandom());
    draw_char(8'd255, pick_pos(), 5, 5, $urandom());
  endtask

  // One random step: a noise load, an unprintable draw, or a prepared glyph draw
  task automatic random_step();
    int               pick;
    logic [CODE_W-1:0] code;
    fill_mode_t       mode;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      load_bit($urandom_range(0, SHEET_DEPTH - 1), $urandom_range(0, 1));
    end else if (pick < 22) begin
      code = $urandom_range(0, 1) ? $urandom_range(0, FIRST_CODE - 1)
                                  : $urandom_range(LAST_CODE + 1, 255);
      draw_char(code, pick_pos(), $urandom_range(0, SCREEN_X_MAX),
                $urandom_range(0, SCREEN_Y_MAX), $urandom());
    end else begin
      code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 8)       mode = FILL_BLANK;
      else if (pick < 16) mode = FILL_SOLID;
      else if (pick < 30) mode = FILL_RANDOM;
      else                mode = FILL_MISSING;
      paint_glyph(code, mode);
      draw_char(code, pick_pos(), $urandom_range(0, SCREEN_X_MAX),
                $urandom_range(0, SCREEN_Y_MAX), $urandom());
    end
  endtask

  initial begin : stimulus
    logic [SIDE_W-1:0] w, h;
    logic [CPR_W-1:0]  cpr;
    int                setting_base;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_GLYPH_WIDTH;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.func          = FUNC_LOAD;
    in_ch.sheet_address = '0;
    in_ch.sheet_black   = 1'b0;
    in_ch.char_code     = '0;
    in_ch.char_position = '0;
    in_ch.origin_x      = '0;
    in_ch.origin_y      = '0;
    in_ch.pen_color     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_part();

    // geometry cases: smallest, all cells in one sheet row, zero, oversize
    // width on the widest sheet row, mid size with a long hold, oversize height, random
    for (int k = 0; k < N_SETTINGS; k++) begin
      settle(1'b1);
      case (k)
        0: begin w = 4'd1;  h = 4'd1; cpr = 7'd1;   end
        1: begin w = 4'd8;  h = 4'd2; cpr = 7'd95;  end
        2: begin w = 4'd0;  h = 4'd0; cpr = 7'd0;   end
        3: begin w = 4'd15; h = 4'd3; cpr = 7'd127; end
        4: begin w = 4'd4;  h = 4'd4; cpr = CELLS_PER_ROW_RST; end
        5: begin w = 4'd2;  h = 4'd9; cpr = 7'd5;   end
        default: begin
          w   = $urandom_range(0, 15);
          h   = $urandom_range(0, 3);
          cpr = $urandom_range(0, 127);
        end
      endcase
      write_regs(w, h, cpr, k == 3);
      for (int p = 0; p < POOL_SIZE; p++)
        code_pool[p] = CODE_W'($urandom_range(FIRST_CODE, LAST_CODE));
      setting_base = items_sent;
      for (int s = 0; items_sent < setting_base + ITEMS_PER_SETTING; s++) begin
        // receiver holds off while words keep coming
        if (k == 4 && s == 0) begin
          hold_req <= hold_req + 1;
          paint_glyph(code_pool[0], FILL_SOLID);
          draw_char(code_pool[0], pick_pos(), $urandom_range(0, SCREEN_X_MAX),
                    $urandom_range(0, SCREEN_Y_MAX), $urandom());
        end
        // sender waits out every pending pixel
        if (k == 1 && s == 1) settle(1'b0);
        random_step();
      end
    end

    settle(1'b1);
    if (errors == 0 && outstanding == 0) begin
      $display("font_sheet_glyph_blitter_top_tb OK");
    end else begin
      $display("font_sheet_glyph_blitter_top_tb NOT OK");
    end
    $finish;
  end

endmodule
